// ===== src/keta_pkg.sv =====
`default_nettype none

package keta_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int KEY_W   = 64;
  localparam int STAMP_W = 32;
  localparam int AGE_W   = 16;
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 6;
  localparam int STAT_W  = 2;
  localparam int RCNT_W  = 7;
  localparam int OCC_W   = 7;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS    = 2 * KEY_W + STAMP_W + SLOT_W;
  localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + SLOT_W + STAT_W + RCNT_W + OCC_W;
  localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = AGE_W'(60);

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_SWEEP  = 2'd1,
    OP_MARK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // One stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]   key_hi;
    logic [KEY_W-1:0]   key_lo;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Request payload, key_upper in the low bits, pad at the top
  typedef struct packed {
    logic [S_TDATA_W-IN_BITS-1:0] pad;
    logic [SLOT_W-1:0]            mark_slot;
    logic [STAMP_W-1:0]           now_seconds;
    logic [KEY_W-1:0]             key_lower;
    logic [KEY_W-1:0]             key_upper;
  } in_t;

  // Result payload, hit in the low bits, pad at the top
  typedef struct packed {
    logic [M_TDATA_W-OUT_BITS-1:0] pad;
    logic [OCC_W-1:0]              occupancy;
    logic [RCNT_W-1:0]             removed_count;
    logic [STAT_W-1:0]             status;
    logic [SLOT_W-1:0]             slot;
    logic                          hit;
  } res_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic key_eq;
    logic expired;
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== src/keta_ram.sv =====
`default_nettype none

module keta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/keta_cmp.sv =====
`default_nettype none

module keta_cmp
  import keta_pkg::*;
(
  input  wire entry_t             ent,
  input  wire logic [KEY_W-1:0]   key_hi,
  input  wire logic [KEY_W-1:0]   key_lo,
  input  wire logic [STAMP_W-1:0] now_seconds,
  input  wire logic [AGE_W-1:0]   age_limit,
  output cmp_res_t                res
);

  logic [STAMP_W-1:0] age;

  // Absolute age, larger stamp minus smaller
  always_comb begin
    if (now_seconds >= ent.stamp) begin
      age = now_seconds - ent.stamp;
    end else begin
      age = ent.stamp - now_seconds;
    end
  end

  assign res.key_eq  = (ent.key_hi == key_hi) && (ent.key_lo == key_lo);
  assign res.expired = (age >= STAMP_W'(age_limit));

endmodule

`default_nettype wire

// ===== src/keyed_table_with_age_expiry_top.sv =====
// Channel  Direction  Fields (low bit up)
// s_*      in         tuser: op; tdata: key_upper, key_lower, now_seconds, mark_slot
// m_*      out        tdata: hit, slot, status, removed_count, occupancy
// cfg_*    in         cfg_wdata: age_limit
//
// Lookup and sweep walk the table one entry per cycle through the entry RAM read
// port and the shared compare unit, up to the occupancy; a lookup hit stops early.
// An empty table, mark and the unused op skip the walk and go to the finish step.
// One request in flight: s_tready is high only between requests. A finished
// result waits in the output register; a new request is taken meanwhile and its
// result holds in the last step until the output register frees up.
// rst is synchronous; table contents need no clearing pass, only flags and count.
`default_nettype none

module keyed_table_with_age_expiry_top
  import keta_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // key_upper, key_lower, now_seconds, mark_slot
  input  wire logic [OP_W-1:0]      s_tuser,   // op
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata,   // hit, slot, status, removed_count, occupancy
  input  wire logic                 cfg_we,
  input  wire logic [AGE_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  // Request registers
  in_t  in_q;
  op_t  op_q;
  in_t  in_w;

  // Table control
  logic [AGE_W-1:0]       age_limit;
  logic [CNT_W-1:0]       count;
  logic [TABLE_DEPTH-1:0] mark_flags;

  // Walk registers
  logic [CNT_W-1:0]  rd_idx;
  logic              pv;
  logic [IDX_W-1:0]  pr_idx;
  logic [CNT_W-1:0]  keep;
  logic [RCNT_W-1:0] removed;
  logic              dropped;
  logic              hit_found;
  logic [IDX_W-1:0]  hit_slot;

  res_t res_q;
  res_t res_next;

  entry_t   rd_ent;
  entry_t   wr_ent;
  cmp_res_t cmp;

  logic                   ram_we;
  logic                   cur_flag;
  logic                   proc_drop;
  logic                   proc_hit;
  logic                   proc_keep;
  logic                   last;
  logic                   out_free;
  logic                   fin_append;
  logic                   compacting;
  logic                   mark_ok;
  logic [TABLE_DEPTH-1:0] keep_mask;

  assign in_w     = in_t'(s_tdata);
  assign s_tready = (state == S_IDLE);
  assign m_tdata  = res_q;
  assign out_free = !m_tvalid || m_tready;

  // Entry storage
  keta_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (keep[IDX_W-1:0]),
    .wdata (wr_ent),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_ent)
  );

  // Shared key and age compare
  keta_cmp u_cmp (
    .ent         (rd_ent),
    .key_hi      (in_q.key_upper),
    .key_lo      (in_q.key_lower),
    .now_seconds (in_q.now_seconds),
    .age_limit   (age_limit),
    .res         (cmp)
  );

  // Per-entry decision during the walk
  always_comb begin
    cur_flag  = mark_flags[pr_idx];
    proc_drop = 1'b0;
    proc_hit  = 1'b0;
    if (op_q == OP_SWEEP) begin
      proc_drop = cmp.expired || cur_flag;
    end else begin
      proc_drop = !dropped && cmp.key_eq && cur_flag;
      proc_hit  = !dropped && cmp.key_eq && !cur_flag;
    end
    proc_keep = pv && !proc_drop && !proc_hit;
    last      = ({1'b0, pr_idx} == CNT_W'(count - 1'b1));
  end

  // Write port: shift a kept entry down, or append the new key
  assign fin_append = (state == S_FINISH) && out_free && (op_q == OP_LOOKUP) && !hit_found
                      && (keep < CNT_W'(TABLE_DEPTH));
  assign ram_we     = ((state == S_WALK) && proc_keep && (keep != {1'b0, pr_idx}))
                      || fin_append;
  assign wr_ent     = fin_append ? entry_t'({in_q.key_upper, in_q.key_lower, in_q.now_seconds})
                                 : rd_ent;

  // Flags at or above the new count are cleared after compaction
  always_comb begin
    for (int b = 0; b < TABLE_DEPTH; b++) begin
      keep_mask[b] = (CNT_W'(b) < keep);
    end
  end

  assign mark_ok    = ({1'b0, in_q.mark_slot} < count);
  assign compacting = (op_q == OP_SWEEP) || ((op_q == OP_LOOKUP) && !hit_found);

  // Result of the finished request
  always_comb begin
    res_next = '0;
    unique case (op_q)
      OP_LOOKUP: begin
        res_next.occupancy = OCC_W'(count);
        if (hit_found) begin
          res_next.hit  = 1'b1;
          res_next.slot = SLOT_W'(hit_slot);
        end else if (keep >= CNT_W'(TABLE_DEPTH)) begin
          res_next.status    = ST_FULL;
          res_next.occupancy = OCC_W'(keep);
        end else begin
          res_next.slot          = SLOT_W'(keep[IDX_W-1:0]);
          res_next.removed_count = removed;
          res_next.occupancy     = OCC_W'(keep + 1'b1);
        end
      end
      OP_SWEEP: begin
        res_next.removed_count = removed;
        res_next.occupancy     = OCC_W'(keep);
      end
      OP_MARK: begin
        res_next.slot      = in_q.mark_slot;
        res_next.status    = mark_ok ? ST_OK : ST_RANGE;
        res_next.occupancy = OCC_W'(count);
      end
      OP_NONE: begin
        res_next.occupancy = OCC_W'(count);
      end
      default: begin
        res_next.occupancy = OCC_W'(count);
      end
    endcase
  end

  // Sequencer, table control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      count      <= '0;
      mark_flags <= '0;
      age_limit  <= AGE_LIMIT_RST;
      pv         <= 1'b0;
    end else begin
      if (cfg_we) begin
        age_limit <= cfg_wdata;
      end
      // A result taken while the next one finishes is replaced below
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_q      <= in_w;
            op_q      <= op_t'(s_tuser);
            rd_idx    <= '0;
            pv        <= 1'b0;
            keep      <= '0;
            removed   <= '0;
            dropped   <= 1'b0;
            hit_found <= 1'b0;
            if (((op_t'(s_tuser) == OP_LOOKUP) || (op_t'(s_tuser) == OP_SWEEP))
                && (count != '0)) begin
              state <= S_WALK;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_WALK: begin
          // Issue the next read
          if (rd_idx < count) begin
            rd_idx <= rd_idx + 1'b1;
            pv     <= 1'b1;
            pr_idx <= rd_idx[IDX_W-1:0];
          end else begin
            pv <= 1'b0;
          end
          // Judge the entry read last cycle
          if (pv) begin
            if (proc_hit) begin
              hit_found <= 1'b1;
              hit_slot  <= pr_idx;
            end else if (proc_drop) begin
              removed <= removed + 1'b1;
              dropped <= 1'b1;
            end else begin
              mark_flags[keep[IDX_W-1:0]] <= cur_flag;
              keep                        <= keep + 1'b1;
            end
            if (proc_hit || last) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            res_q    <= res_next;
            count    <= CNT_W'(res_next.occupancy);
            if (compacting) begin
              mark_flags <= mark_flags & keep_mask;
            end else if ((op_q == OP_MARK) && mark_ok) begin
              mark_flags[in_q.mark_slot[IDX_W-1:0]] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/keta_checker.sv =====
`default_nettype none

module keta_checker
  import keta_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  res_t res;
  assign res = res_t'(m_tdata);

  // One request at a time: no new request right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted twice in a row");

  // Occupancy never exceeds the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.occupancy <= OCC_W'(TABLE_DEPTH)))
    else $error("occupancy beyond table depth");

  // A hit removes nothing and reports ok
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.hit) |-> ((res.status == ST_OK) && (res.removed_count == '0)))
    else $error("hit with removal or bad status");

  // A full table leaves occupancy at the table size
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res.status == ST_FULL)) |-> (res.occupancy == OCC_W'(TABLE_DEPTH)))
    else $error("full status with room left");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind keyed_table_with_age_expiry_top keta_checker u_keta_checker (.*);

`default_nettype wire

// ===== bench/keyed_table_with_age_expiry_top_test.sv =====
`timescale 1ns / 1ps

module keyed_table_with_age_expiry_top_test;
  import keta_pkg::*;

  localparam int NKEYS       = 96;
  localparam int NPHASES     = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1_500_000;

  // Table tracker: mirrors entries, marks and count; queues predicted results
  class age_table_board;
    bit [KEY_W-1:0]   key_hi [TABLE_DEPTH];
    bit [KEY_W-1:0]   key_lo [TABLE_DEPTH];
    bit [STAMP_W-1:0] stamp  [TABLE_DEPTH];
    bit               marked [TABLE_DEPTH];
    int unsigned      count;
    bit [AGE_W-1:0]   age_limit;
    res_t             predicted_q[$];
    int unsigned      errors;

    function new();
      count     = 0;
      age_limit = AGE_LIMIT_RST;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return predicted_q.size();
    endfunction

    // Apply one accepted request to the table and queue its result
    function void note_request(op_t op, in_t req);
      res_t            r;
      int              pos;
      int unsigned     keep;
      int unsigned     removed;
      bit [STAMP_W-1:0] age;
      r       = '0;
      removed = 0;
      case (op)
        OP_LOOKUP: begin
          pos = -1;
          for (int i = 0; i < count; i++) begin
            if (key_hi[i] == req.key_upper && key_lo[i] == req.key_lower) begin
              pos = i;
              break;
            end
          end
          if (pos >= 0 && !marked[pos]) begin
            r.hit  = 1'b1;
            r.slot = pos[SLOT_W-1:0];
          end else begin
            // marked match: drop it and shift the tail down, then insert anew
            if (pos >= 0) begin
              for (int i = pos; i + 1 < count; i++) begin
                key_hi[i] = key_hi[i+1];
                key_lo[i] = key_lo[i+1];
                stamp[i]  = stamp[i+1];
                marked[i] = marked[i+1];
              end
              count--;
              marked[count] = 1'b0;
              removed = 1;
            end
            if (count >= TABLE_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              key_hi[count] = req.key_upper;
              key_lo[count] = req.key_lower;
              stamp[count]  = req.now_seconds;
              marked[count] = 1'b0;
              r.slot        = count[SLOT_W-1:0];
              count++;
            end
          end
        end
        OP_SWEEP: begin
          keep = 0;
          for (int i = 0; i < count; i++) begin
            age = (req.now_seconds >= stamp[i]) ? req.now_seconds - stamp[i]
                                                 : stamp[i] - req.now_seconds;
            if (age >= age_limit || marked[i]) begin
              removed++;
            end else begin
              key_hi[keep] = key_hi[i];
              key_lo[keep] = key_lo[i];
              stamp[keep]  = stamp[i];
              marked[keep] = marked[i];
              keep++;
            end
          end
          for (int i = keep; i < count; i++) marked[i] = 1'b0;
          count = keep;
        end
        OP_MARK: begin
          r.slot = req.mark_slot;
          if (req.mark_slot < count) marked[req.mark_slot] = 1'b1;
          else r.status = ST_RANGE;
        end
        default: ;
      endcase
      r.removed_count = removed[RCNT_W-1:0];
      r.occupancy     = count[OCC_W-1:0];
      predicted_q.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result against the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (predicted_q.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = predicted_q.pop_front();
      check_field("hit", 8'(want.hit), 8'(got.hit));
      check_field("slot", 8'(want.slot), 8'(got.slot));
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("removed_count", 8'(want.removed_count), 8'(got.removed_count));
      check_field("occupancy", 8'(want.occupancy), 8'(got.occupancy));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // key_upper, key_lower, now_seconds, mark_slot
  logic [OP_W-1:0]      s_tuser;   // op
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // hit, slot, status, removed_count, occupancy
  logic                 cfg_we;
  logic [AGE_W-1:0]     cfg_wdata;

  age_table_board   board = new();
  bit [KEY_W-1:0]   pool_hi [NKEYS];
  bit [KEY_W-1:0]   pool_lo [NKEYS];
  bit [STAMP_W-1:0] t_now;
  bit               calm_tx;
  bit               calm_rx;
  bit               long_hold_req;

  // Per-phase knobs
  int unsigned sweep_pct [NPHASES] = '{8, 6, 0, 10, 8, 4, 10, 8};
  int unsigned key_span  [NPHASES] = '{48, 96, 96, 40, 64, 96, 48, 64};

  keyed_table_with_age_expiry_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request, wait for it to be taken, then maybe idle
  task automatic send_request(input op_t op, input in_t req);
    int gap;
    s_tuser  <= op;
    s_tdata  <= req;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_request(op, req);
    gap = pick_gap(calm_tx);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(input op_t op, input bit [KEY_W-1:0] khi, input bit [KEY_W-1:0] klo,
                       input bit [STAMP_W-1:0] now, input bit [SLOT_W-1:0] ms);
    in_t req;
    req             = '0;
    req.key_upper   = khi;
    req.key_lower   = klo;
    req.now_seconds = now;
    req.mark_slot   = ms;
    send_request(op, req);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_age_limit(input bit [AGE_W-1:0] v);
    drain(8);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    board.age_limit = v;
    cfg_we <= 1'b0;
  endtask

  // One random request; lookups draw keys from a small pool to get hits
  task automatic random_request(input int unsigned span, input int unsigned sweep_w);
    int unsigned      r;
    int unsigned      p;
    int unsigned      k;
    op_t              op;
    bit [KEY_W-1:0]   khi;
    bit [KEY_W-1:0]   klo;
    bit [STAMP_W-1:0] now;
    bit [SLOT_W-1:0]  ms;
    r   = $urandom_range(0, 99);
    p   = $urandom_range(0, 99);
    khi = {$urandom, $urandom};
    klo = {$urandom, $urandom};
    ms  = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    t_now += $urandom_range(0, 3);
    now = t_now;
    if (r < 4) begin
      op  = OP_NONE;
      now = $urandom;
    end else if (r < 4 + sweep_w) begin
      op = OP_SWEEP;
      if (p >= 85) now = $urandom;
      else if (p >= 65) now = t_now - $urandom_range(0, 80);
    end else if (r < 26 + sweep_w) begin
      op = OP_MARK;
      if (board.count > 0 && p < 80) ms = SLOT_W'($urandom_range(0, board.count - 1));
    end else begin
      op = OP_LOOKUP;
      if (p < 88) begin
        k   = $urandom_range(0, span - 1);
        khi = pool_hi[k];
        klo = pool_lo[k];
      end
      if ($urandom_range(0, 99) < 6) now = $urandom;
    end
    issue(op, khi, klo, now, ms);
  endtask

  // Result side: check accepted results, stall at random, one long hold on request
  initial begin
    int stall;
    stall = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0) begin
        stall = pick_gap(calm_rx);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("keyed_table_with_age_expiry_top: mismatch");
    $finish;
  end

  initial begin
    bit [AGE_W-1:0] age;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_LOOKUP;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    calm_tx       = 1'b0;
    calm_rx       = 1'b0;
    long_hold_req = 1'b0;
    for (int i = 0; i < NKEYS; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    // keys that agree in one half only
    pool_hi[1] = pool_hi[0];
    pool_lo[2] = pool_lo[0];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: reset age limit, key extremes, marks, range errors, boundary ages
    issue(OP_SWEEP,  '0, '0, 32'd0, '0);                  // sweep on empty table
    issue(OP_LOOKUP, '0, '0, 32'd0, '0);                  // all-zero key
    issue(OP_LOOKUP, '1, '1, 32'hFFFF_FFFF, '1);          // all-ones key, top stamp
    issue(OP_LOOKUP, '0, '0, 32'd5, '0);                  // hit
    issue(OP_LOOKUP, pool_hi[0], pool_lo[0], 32'd100, '0);
    issue(OP_LOOKUP, pool_hi[1], pool_lo[1], 32'd100, '0); // same upper half
    issue(OP_LOOKUP, pool_hi[2], pool_lo[2], 32'd100, '0); // same lower half
    issue(OP_MARK,   '0, '0, 32'd0, 6'd1);
    issue(OP_MARK,   '0, '0, 32'd0, 6'd1);                // mark an already marked entry
    issue(OP_MARK,   '0, '0, 32'd0, 6'd63);               // beyond occupancy
    issue(OP_MARK,   '0, '0, 32'd0, 6'd5);                // exactly at occupancy
    issue(OP_LOOKUP, '1, '1, 32'hFFFF_FFFF, '0);          // marked match, reinsert
    issue(OP_NONE,   {$urandom, $urandom}, {$urandom, $urandom}, $urandom, '1);
    issue(OP_MARK,   '0, '0, 32'd0, 6'd1);
    issue(OP_SWEEP,  '0, '0, 32'd100, '0);                // old, marked and far-future go
    issue(OP_SWEEP,  '0, '0, 32'd41, '0);                 // age just under the limit
    issue(OP_SWEEP,  '0, '0, 32'd40, '0);                 // age exactly at the limit

    // Random phases, each with its own age limit and traffic mix
    t_now = 32'd1000;
    for (int p = 0; p < NPHASES; p++) begin
      case (p)
        0:       age = '0;
        1:       age = '1;
        2:       age = 16'd60;
        3:       age = 16'd1;
        5:       age = 16'd300;
        7:       age = 16'd20;
        default: age = AGE_W'($urandom_range(2, 65534));
      endcase
      write_age_limit(age);
      calm_tx       = (p == 3) || (p == 6);
      calm_rx       = (p == 3);
      long_hold_req = (p == 1) || (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(key_span[p], sweep_pct[p]);
    end

    drain(TAIL_CYCLES);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("keyed_table_with_age_expiry_top: match");
    end else begin
      $display("keyed_table_with_age_expiry_top: mismatch");
    end
    $finish;
  end

endmodule
